FILE: sv/ship_rrip_stream_bypass_replacer_top_assert.svh
// Assertion macros used by the replacer controller.
`ifndef SHIP_RRIP_STREAM_BYPASS_REPLACER_TOP_ASSERT_SVH
`define SHIP_RRIP_STREAM_BYPASS_REPLACER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SRB_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SRB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

FILE: sv/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants of the replacer.
// ----------------------------------------------------------------------------
package srb_pkg;
   localparam logic [1:0] RRPV_MAX = 2'd3;
   localparam logic [1:0] CTR_MAX = 2'd3;
   localparam logic [2:0] STREAM_MAX = 3'd7;
   localparam logic [1:0] REUSE_MAX = 2'd3;
   localparam logic [1:0] REG_STREAM = 2'd0;
   localparam logic [1:0] REG_LIVE = 2'd1;
   localparam logic [1:0] REG_NEAR = 2'd2;

   // Commands from controller to datapath.
   typedef struct packed {
      logic clear;     // clear the next row and counter entry, each if in range, after reset
      logic capture;   // latch request fields
      logic read_row;  // issue memory reads
      logic compute;   // evaluate, produce result and write data
      logic write_row; // write memories
      logic rsp_load;  // load response register
   } cmd_type;

   typedef struct packed {
      logic clear_last; // the clearing pass is on its last entry
   } status_type;
endpackage

FILE: sv/srb_datapath.sv
// ----------------------------------------------------------------------------
// srb_datapath
// Set row memories, signature table, leader state and the decision logic.
// ----------------------------------------------------------------------------
module srb_datapath #(
   parameter int NUM_SETS = 2048,
   parameter int NUM_WAYS = 16,
   parameter int SIG_WIDTH = 6,
   parameter int LEADER_SETS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  srb_pkg::cmd_type      cmd,
   output srb_pkg::status_type   status,
   input  logic                  req_mode,
   input  logic [10:0]           req_set_index,
   input  logic [3:0]            req_way_index,
   input  logic [63:0]           req_pc,
   input  logic [63:0]           req_phys_addr,
   input  logic                  req_is_hit,
   input  logic [15:0]           req_valid_mask,
   input  logic [2:0]            stream_confirm_count,
   input  logic [1:0]            live_threshold,
   input  logic [1:0]            near_insert_rrpv,
   output logic [3:0]            rsp_victim_way,
   output logic                  rsp_fill_bypassed
);
   import srb_pkg::*;
   localparam int SW = $clog2(NUM_SETS);
   localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int LW = (LEADER_SETS > 1) ? $clog2(LEADER_SETS) : 1;
   localparam int NSIG = 1 << SIG_WIDTH;
   localparam int RW = NUM_WAYS * (3 + SIG_WIDTH);
   localparam int CLR_N = (NUM_SETS > NSIG) ? NUM_SETS : NSIG;
   localparam int CW = $clog2(CLR_N);

   typedef struct packed {
      logic [1:0] rrpv;
      logic [SIG_WIDTH-1:0] sig;
      logic dead;
   } line_type;

   // A whole set row sits in one memory word. After reset the controller runs
   // a clearing pass that zeroes one in-range row and counter entry per cycle.
   logic [RW-1:0] row_word_mem [NUM_SETS];
   logic [1:0] sctr_mem [NSIG];
   logic [63:0] la_ff [LEADER_SETS];
   logic [63:0] ls_ff [LEADER_SETS];
   logic [2:0]  sc_ff [LEADER_SETS];
   logic [1:0]  rc_ff [LEADER_SETS];

   logic mode_ff, hit_ff;
   logic [SW-1:0] set_ff;
   logic [WW-1:0] way_ff;
   logic [63:0] pc_ff, addr_ff;
   logic [15:0] vm_ff;
   line_type [NUM_WAYS-1:0] rd_row, wr_ff;
   logic [3:0] vic_ff;
   logic byp_ff;
   logic [RW-1:0] rd_word_ff;
   logic [CW-1:0] clr_ff;
   logic [1:0] sctr_rd_ff, sctr_old_ff;
   logic [SIG_WIDTH-1:0] old_sig_ff;

   logic row_we;
   logic [SW-1:0] row_wa;
   logic [RW-1:0] row_wd;
   logic sctr_we;
   logic [SIG_WIDTH-1:0] sctr_wa;
   logic [1:0] sctr_wd;

   assign status.clear_last = clr_ff == CW'(CLR_N - 1);

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear) clr_ff <= clr_ff + CW'(1);
   end

   always_comb begin
      row_we = cmd.write_row;
      row_wa = set_ff;
      row_wd = wr_ff;
      if (!cmd.write_row && cmd.clear && 32'(clr_ff) < NUM_SETS) begin
         row_we = 1'b1;
         row_wa = SW'(clr_ff);
         row_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         hit_ff <= req_is_hit;
         set_ff <= SW'(req_set_index);
         way_ff <= WW'(req_way_index);
         pc_ff <= req_pc;
         addr_ff <= req_phys_addr;
         vm_ff <= req_valid_mask;
      end
      if (cmd.read_row) rd_word_ff <= row_word_mem[set_ff];
      if (row_we) row_word_mem[row_wa] <= row_wd;
   end

   assign rd_row = rd_word_ff;

   logic [SIG_WIDTH-1:0] sig;
   assign sig = SIG_WIDTH'(pc_ff ^ (pc_ff >> 6) ^ (pc_ff >> 12));
   logic leader;
   assign leader = 32'(set_ff) < LEADER_SETS;
   logic [LW-1:0] li;
   assign li = LW'(set_ff);
   logic [63:0] stride;
   assign stride = addr_ff - la_ff[li];

   logic [2:0] sc_n;
   logic [1:0] rc_n;
   logic streaming;
   logic [3:0] vic;
   logic byp;
   line_type [NUM_WAYS-1:0] wr_n;
   logic [1:0] top, add;
   logic found;
   logic [SIG_WIDTH-1:0] old_sig;
   logic [1:0] ins;

   always_comb begin
      sc_n = sc_ff[li];
      rc_n = rc_ff[li];
      if (ls_ff[li] != 64'd0 && stride == ls_ff[li]) begin
         if (sc_n < STREAM_MAX) sc_n = sc_n + 3'd1;
      end else begin
         sc_n = 3'd0;
      end
      streaming = leader && sc_n >= stream_confirm_count && rc_ff[li] == 2'd0;
      wr_n = rd_row;
      vic = '0;
      byp = 1'b0;
      found = 1'b0;
      top = '0;
      add = '0;
      old_sig = rd_row[way_ff].sig;
      ins = RRPV_MAX;
      if (!mode_ff) begin
         for (int w = 0; w < NUM_WAYS; w++)
            if (!found && w < 16 && !vm_ff[w % 16]) begin
               found = 1'b1; vic = 4'(w);
            end
         for (int w = 0; w < NUM_WAYS; w++)
            if (!found && rd_row[w].dead) begin
               found = 1'b1; vic = 4'(w);
            end
         if (!found) begin
            for (int w = 0; w < NUM_WAYS; w++)
               if (rd_row[w].rrpv > top) top = rd_row[w].rrpv;
            add = RRPV_MAX - top;
            for (int w = 0; w < NUM_WAYS; w++)
               wr_n[w].rrpv = rd_row[w].rrpv + add;
            for (int w = NUM_WAYS - 1; w >= 0; w--)
               if (wr_n[w].rrpv == RRPV_MAX) vic = 4'(w);
         end
      end else if (hit_ff) begin
         wr_n[way_ff].rrpv = 2'd0;
         wr_n[way_ff].sig = sig;
         wr_n[way_ff].dead = 1'b0;
         if (rc_n < REUSE_MAX) rc_n = rc_n + 2'd1;
      end else if (streaming) begin
         wr_n[way_ff].rrpv = RRPV_MAX;
         wr_n[way_ff].sig = sig;
         wr_n[way_ff].dead = 1'b1;
         byp = 1'b1;
      end else begin
         if (sctr_rd_ff >= live_threshold) ins = near_insert_rrpv;
         if (rd_row[way_ff].dead) ins = RRPV_MAX;
         wr_n[way_ff].rrpv = ins;
         wr_n[way_ff].sig = sig;
         wr_n[way_ff].dead = 1'b0;
         if (rc_n > 2'd0) rc_n = rc_n - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compute) begin
         wr_ff <= wr_n;
         vic_ff <= vic;
         byp_ff <= byp;
      end
      if (cmd.rsp_load) begin
         rsp_victim_way <= vic_ff;
         rsp_fill_bypassed <= byp_ff;
      end
   end

   // On updates a hit raises the new signature's counter; a miss decays the old one.
   always_comb begin
      sctr_we = 1'b0;
      sctr_wa = sig;
      sctr_wd = sctr_rd_ff + 2'd1;
      if (cmd.write_row && mode_ff) begin
         if (hit_ff) begin
            sctr_we = sctr_rd_ff < CTR_MAX;
         end else begin
            sctr_we = sctr_old_ff > 2'd0;
            sctr_wa = old_sig_ff;
            sctr_wd = sctr_old_ff - 2'd1;
         end
      end else if (cmd.clear && 32'(clr_ff) < NSIG) begin
         sctr_we = 1'b1;
         sctr_wa = SIG_WIDTH'(clr_ff);
         sctr_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_row) sctr_rd_ff <= sctr_mem[sig];
      if (cmd.compute) begin
         sctr_old_ff <= sctr_mem[old_sig];
         old_sig_ff <= old_sig;
      end
      if (sctr_we) sctr_mem[sctr_wa] <= sctr_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEADER_SETS; i++) begin
            la_ff[i] <= '0; ls_ff[i] <= '0; sc_ff[i] <= '0; rc_ff[i] <= '0;
         end
      end else if (cmd.compute && mode_ff) begin
         if (leader) begin
            la_ff[li] <= addr_ff;
            ls_ff[li] <= stride;
            sc_ff[li] <= sc_n;
            rc_ff[li] <= rc_n;
         end
      end
   end
endmodule

FILE: sv/srb_ctrl.sv
// ----------------------------------------------------------------------------
// srb_ctrl
// Sequencer: clearing pass, capture, read row, compute, write row and respond.
// ----------------------------------------------------------------------------
module srb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  srb_pkg::status_type status,
   output srb_pkg::cmd_type    cmd
);
   import srb_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_CALC = 3'd2,
                          S_WRITE = 3'd3, S_HOLD = 3'd4, S_CLEAR = 3'd5;
   logic [2:0] state_ff, state_in;
   logic rv_ff, rv_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      rv_in = rv_ff;
      cmd = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: if (req_valid) begin cmd.capture = 1'b1; state_in = S_READ; end
         S_READ: begin cmd.read_row = 1'b1; state_in = S_CALC; end
         S_CALC: begin cmd.compute = 1'b1; state_in = S_WRITE; end
         S_WRITE: begin cmd.write_row = 1'b1; state_in = S_HOLD; end
         S_HOLD: if (!rv_ff || rsp_ready) begin
            cmd.rsp_load = 1'b1; rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
   end

`include "ship_rrip_stream_bypass_replacer_top_assert.svh"
   `SRB_ASSERT_NEXT(a_cap_read, clock, reset, cmd.capture, state_ff == S_READ)
   `SRB_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, !cmd.write_row)
   `SRB_ASSERT_NEXT(a_load_valid, clock, reset, cmd.rsp_load, rsp_valid)
endmodule

FILE: sv/ship_rrip_stream_bypass_replacer_top.sv
// ----------------------------------------------------------------------------
// ship_rrip_stream_bypass_replacer_top
// Signature-predicted RRIP replacement with leader-set stream bypass.
// ----------------------------------------------------------------------------
// Each request item on req_ carries a victim query or an update. It is taken
// when req_valid and req_ready are high, and one result item appears on rsp_.
// An item passes capture, row read, compute, row write and result load, and
// the block takes no new item until the result of the last one is loaded.
// rsp_valid is registered and rises with the result load after the row write.
// A result waits in the output register while rsp_ready is low; the next item
// may already be processed but is held before its own result is loaded.
// At reset the sequencer runs a clearing pass over NUM_SETS entries (or
// 2^SIG_WIDTH where that is larger; 2048 at the defaults) that zeroes the set
// rows and signature counters; req_ready stays low until it ends. Leader
// state clears at once and configuration takes its default values.
// The APB-style p port (psel, penable) is always ready; writes land on the access cycle.
// ----------------------------------------------------------------------------
module ship_rrip_stream_bypass_replacer_top #(
   parameter int NUM_SETS = 2048,
   parameter int NUM_WAYS = 16,
   parameter int SIG_WIDTH = 6,
   parameter int LEADER_SETS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [10:0] req_set_index,
   input  logic [3:0]  req_way_index,
   input  logic [63:0] req_pc,
   input  logic [63:0] req_phys_addr,
   input  logic        req_is_hit,
   input  logic [15:0] req_valid_mask,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_victim_way,
   output logic        rsp_fill_bypassed,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import srb_pkg::*;
   cmd_type cmd;
   status_type status;
   logic [2:0] scc_ff;
   logic [1:0] lt_ff, nir_ff;
   logic [1:0] ridx;
   assign ridx = paddr[3:2];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scc_ff <= 3'd4; lt_ff <= 2'd2; nir_ff <= 2'd1;
      end else if (psel && penable && pwrite) begin
         unique case (ridx)
            REG_STREAM: scc_ff <= pwdata[2:0];
            REG_LIVE: lt_ff <= pwdata[1:0];
            REG_NEAR: nir_ff <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         REG_STREAM: prdata = {29'd0, scc_ff};
         REG_LIVE: prdata = {30'd0, lt_ff};
         REG_NEAR: prdata = {30'd0, nir_ff};
         default: prdata = '0;
      endcase
   end

   srb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status), .cmd(cmd)
   );

   srb_datapath #(
      .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_WIDTH(SIG_WIDTH),
      .LEADER_SETS(LEADER_SETS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_mode(req_mode), .req_set_index(req_set_index),
      .req_way_index(req_way_index), .req_pc(req_pc),
      .req_phys_addr(req_phys_addr), .req_is_hit(req_is_hit),
      .req_valid_mask(req_valid_mask), .stream_confirm_count(scc_ff),
      .live_threshold(lt_ff), .near_insert_rrpv(nir_ff),
      .rsp_victim_way(rsp_victim_way), .rsp_fill_bypassed(rsp_fill_bypassed)
   );
endmodule
